// ----- rtl/sscq_pkg.sv -----
package sscq_pkg;

   // defaults for the top level parameters
   localparam int STORE_SLOTS_DEF = 8;
   localparam int QUEUE_SLOTS_DEF = 16;
   localparam int KEY_BITS_DEF    = 48;

   // fixed field widths on the ports
   localparam int KEY_PORT_BITS   = 48;
   localparam int POSITION_BITS   = 5;
   localparam int STORE_CNT_BITS  = 4;
   localparam int QUEUE_CNT_BITS  = 5;

   typedef enum logic [1:0] {
      OP_PARK   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_PARKED    = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_IN_STORE  = 3'd6,
      ST_IN_QUEUE  = 3'd7
   } status_type;

   // per-cell update control: load has priority over shift
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- rtl/slot_stack_with_overflow_queue_unit.sv -----
// Ordered key store of STORE_SLOTS slots (slot 1 at the bottom) backed by an
// overflow queue of QUEUE_SLOTS keys. A park request appends the key on top of
// the store, or queues it when the store is full, or drops it when the queue
// is full too. A remove request deletes the topmost matching key, closes the
// gap and refills the top from the queue head. A search request reports the
// bottommost matching store slot, else the queue position. Both the store and
// the queue are rows of identical cells that compare every key against the
// request at once and shift keys to their lower neighbor when an entry leaves,
// so the queue head always sits in cell 0. On accept every cell registers its
// match bit; the evaluation state then picks the winning cell, updates the
// rows and loads the response register once the response slot is free. The next
// request is taken while the response waits; it completes once the response
// has been taken. Requests with the unused op code are swallowed without a
// response. rsp_tdata carries counts and positions cut to their port widths.
module slot_stack_with_overflow_queue_unit
   import sscq_pkg::*;
#(
   parameter int STORE_SLOTS = STORE_SLOTS_DEF,
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // key[47:0]
   input  logic [1:0]  req_tuser,    // op[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // position[4:0], refilled[5], refilled_key[53:6],
                                     // store_count[57:54], queue_count[62:58], zero[63]
   output logic [2:0]  rsp_tuser     // status[2:0]
);

   // counter and index widths follow the row lengths
   localparam int SCW = $clog2(STORE_SLOTS + 1);
   localparam int QCW = $clog2(QUEUE_SLOTS + 1);
   localparam int SIW = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SCW-1:0]      scount_ff, scount_in;
   logic [QCW-1:0]      qcount_ff, qcount_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [POSITION_BITS-1:0]  rsp_position_ff, rsp_position_in;
   logic                      rsp_refilled_ff, rsp_refilled_in;
   logic [KEY_PORT_BITS-1:0]  rsp_refkey_ff, rsp_refkey_in;
   logic [STORE_CNT_BITS-1:0] rsp_scount_ff, rsp_scount_in;
   logic [QUEUE_CNT_BITS-1:0] rsp_qcount_ff, rsp_qcount_in;

   logic req_accept;
   logic eval_fire;

   // cell rows
   cell_ctl_type        s_ctl   [STORE_SLOTS];
   logic [KEY_BITS-1:0] s_key   [STORE_SLOTS];
   logic [STORE_SLOTS-1:0] s_match;
   cell_ctl_type        q_ctl   [QUEUE_SLOTS];
   logic [KEY_BITS-1:0] q_key   [QUEUE_SLOTS];
   logic [QUEUE_SLOTS-1:0] q_match;
   logic [KEY_BITS-1:0] s_load_key;

   // only one request in flight; it finishes when the response slot is free
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign eval_fire  = (state_ff == S_EVAL) && (!rsp_valid_ff || rsp_tready);

   // store row: cell j takes the key of cell j+1 when a slot below empties
   for (genvar j = 0; j < STORE_SLOTS; j++) begin : g_store
      logic [KEY_BITS-1:0] next_key;
      if (j == STORE_SLOTS - 1) begin : g_top
         assign next_key = '0;
      end else begin : g_mid
         assign next_key = s_key[j+1];
      end
      sscq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
         .clock     (clock),
         .cmp_en    (req_accept),
         .cmp_key   (req_tdata[KEY_BITS-1:0]),
         .ctl       (s_ctl[j]),
         .load_key  (s_load_key),
         .next_key  (next_key),
         .key_out   (s_key[j]),
         .match_out (s_match[j])
      );
   end

   // queue row: head lives in cell 0, a pop shifts everything down one cell
   for (genvar j = 0; j < QUEUE_SLOTS; j++) begin : g_queue
      logic [KEY_BITS-1:0] next_key;
      if (j == QUEUE_SLOTS - 1) begin : g_top
         assign next_key = '0;
      end else begin : g_mid
         assign next_key = q_key[j+1];
      end
      sscq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
         .clock     (clock),
         .cmp_en    (req_accept),
         .cmp_key   (req_tdata[KEY_BITS-1:0]),
         .ctl       (q_ctl[j]),
         .load_key  (key_ff),
         .next_key  (next_key),
         .key_out   (q_key[j]),
         .match_out (q_match[j])
      );
   end

   // refill takes the queue head, park takes the request key
   assign s_load_key = (op_ff == OP_REMOVE) ? q_key[0] : key_ff;

   // request capture and state sequencing
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in  = op_type'(req_tuser);
               key_in = req_tdata[KEY_BITS-1:0];
               case (op_type'(req_tuser))
                  OP_PARK, OP_REMOVE, OP_SEARCH: state_in = S_EVAL;
                  default:                       state_in = S_IDLE;
               endcase
            end
         end
         S_EVAL: begin
            if (eval_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // pick the winning cell, drive the row updates, build the response
   always_comb begin
      logic [STORE_SLOTS-1:0] s_hit;
      logic [QUEUE_SLOTS-1:0] q_hit;
      logic [SIW-1:0]         top_idx;
      logic [SIW-1:0]         low_idx;
      logic                   s_found;
      logic [POSITION_BITS-1:0] q_pos;
      logic                   q_found;
      logic [KEY_PORT_BITS-1:0] head_wide;

      for (int j = 0; j < STORE_SLOTS; j++) begin
         s_ctl[j] = '0;
         s_hit[j] = s_match[j] && (SCW'(j) < scount_ff);
      end
      for (int j = 0; j < QUEUE_SLOTS; j++) begin
         q_ctl[j] = '0;
         q_hit[j] = q_match[j] && (QCW'(j) < qcount_ff);
      end

      // topmost store hit for remove, bottommost for search
      top_idx = '0;
      for (int j = 0; j < STORE_SLOTS; j++) begin
         if (s_hit[j]) begin
            top_idx = SIW'(j);
         end
      end
      low_idx = '0;
      for (int j = STORE_SLOTS - 1; j >= 0; j--) begin
         if (s_hit[j]) begin
            low_idx = SIW'(j);
         end
      end
      s_found = |s_hit;
      q_pos   = '0;
      for (int j = QUEUE_SLOTS - 1; j >= 0; j--) begin
         if (q_hit[j]) begin
            q_pos = POSITION_BITS'(j + 1);
         end
      end
      q_found = |q_hit;

      head_wide                = '0;
      head_wide[KEY_BITS-1:0]  = q_key[0];

      scount_in       = scount_ff;
      qcount_in       = qcount_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = '0;
      rsp_refilled_in = 1'b0;
      rsp_refkey_in   = '0;

      if (eval_fire) begin
         case (op_ff)
            OP_PARK: begin
               if (scount_ff < SCW'(STORE_SLOTS)) begin
                  for (int j = 0; j < STORE_SLOTS; j++) begin
                     s_ctl[j].load = (SCW'(j) == scount_ff);
                  end
                  scount_in       = scount_ff + 1'b1;
                  rsp_status_in   = ST_PARKED;
                  rsp_position_in = POSITION_BITS'(scount_ff + 1'b1);
               end else if (qcount_ff < QCW'(QUEUE_SLOTS)) begin
                  for (int j = 0; j < QUEUE_SLOTS; j++) begin
                     q_ctl[j].load = (QCW'(j) == qcount_ff);
                  end
                  qcount_in       = qcount_ff + 1'b1;
                  rsp_status_in   = ST_QUEUED;
                  rsp_position_in = POSITION_BITS'(qcount_ff + 1'b1);
               end else begin
                  rsp_status_in = ST_DROPPED;
               end
            end
            OP_REMOVE: begin
               if (scount_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else if (!s_found) begin
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  rsp_status_in = ST_REMOVED;
                  // close the gap above the deleted slot
                  for (int j = 0; j < STORE_SLOTS - 1; j++) begin
                     s_ctl[j].shift = (j >= int'(top_idx));
                  end
                  if (qcount_ff != '0) begin
                     // queue head lands in the slot freed at the top
                     for (int j = 0; j < STORE_SLOTS; j++) begin
                        s_ctl[j].load = (SCW'(j) == scount_ff - 1'b1);
                     end
                     for (int j = 0; j < QUEUE_SLOTS - 1; j++) begin
                        q_ctl[j].shift = 1'b1;
                     end
                     qcount_in       = qcount_ff - 1'b1;
                     rsp_refilled_in = 1'b1;
                     rsp_refkey_in   = head_wide;
                  end else begin
                     scount_in = scount_ff - 1'b1;
                  end
               end
            end
            OP_SEARCH: begin
               if (s_found) begin
                  rsp_status_in   = ST_IN_STORE;
                  rsp_position_in = POSITION_BITS'(low_idx) + 1'b1;
               end else if (q_found) begin
                  rsp_status_in   = ST_IN_QUEUE;
                  rsp_position_in = q_pos;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = ST_NOT_FOUND;
            end
         endcase
      end

      rsp_scount_in = STORE_CNT_BITS'(scount_in);
      rsp_qcount_in = QUEUE_CNT_BITS'(qcount_in);
   end

   // response handshake: a new response loads as the old one leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eval_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scount_ff    <= '0;
         qcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scount_ff    <= scount_in;
         qcount_ff    <= qcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      if (eval_fire) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
         rsp_refilled_ff <= rsp_refilled_in;
         rsp_refkey_ff   <= rsp_refkey_in;
         rsp_scount_ff   <= rsp_scount_in;
         rsp_qcount_ff   <= rsp_qcount_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_qcount_ff, rsp_scount_ff, rsp_refkey_ff,
                        rsp_refilled_ff, rsp_position_ff};

`ifndef NO_ASSERTIONS
   // store never holds more than its slots
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      scount_ff <= SCW'(STORE_SLOTS))
      else $error("store count above slot limit");

   // keys only wait while every store slot is taken
   a_queue_needs_full_store: assert property (@(posedge clock) disable iff (reset)
      (qcount_ff != '0) |-> (scount_ff == SCW'(STORE_SLOTS)))
      else $error("queue holds keys while the store has room");

   // a response only appears after an evaluation cycle
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EVAL))
      else $error("response raised without evaluation");

   // a refill always leaves the queue one shorter and the store count unchanged
   a_refill_counts: assert property (@(posedge clock) disable iff (reset)
      (eval_fire && rsp_refilled_in) |=>
         (qcount_ff == $past(qcount_ff) - 1'b1) && $stable(scount_ff))
      else $error("refill count update wrong");
`endif

endmodule

// ----- rtl/sscq_cell.sv -----
module sscq_cell
   import sscq_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic                cmp_en,
   input  logic [KEY_BITS-1:0] cmp_key,
   input  cell_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] load_key,
   input  logic [KEY_BITS-1:0] next_key,
   output logic [KEY_BITS-1:0] key_out,
   output logic                match_out
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                match_ff;
   logic                match_in;

   always_comb begin
      key_in = key_ff;
      if (ctl.load) begin
         key_in = load_key;
      end else if (ctl.shift) begin
         key_in = next_key;
      end
   end

   // compare against the broadcast key, held for the update cycle
   assign match_in = cmp_en ? (cmp_key == key_ff) : match_ff;

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign match_out = match_ff;

endmodule
